>>> rtl/svrt_pkg.sv
`timescale 1ns / 1ps

package svrt_pkg;

   localparam int unsigned TABLE_DEPTH_DEFAULT = 16;

   localparam int unsigned VALUE_W   = 8;
   localparam int unsigned ID_W      = 8;
   localparam int unsigned CHANNEL_W = 10;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 10;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_RISE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_FALL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_NUMBER  = 2'd2;

   localparam logic [CHANNEL_W-1:0] SLOT_NUMBER_RESET = 10'd1;

   localparam logic [STATUS_W-1:0] ADD_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ADD_OVERLAP    = 2'd1;
   localparam logic [STATUS_W-1:0] ADD_TABLE_FULL = 2'd2;
   localparam logic [STATUS_W-1:0] ADD_BAD_BOUNDS = 2'd3;

   localparam logic ACTION_SAMPLE = 1'b0;
   localparam logic ACTION_ADD    = 1'b1;

   typedef struct packed {
      logic               valid;
      logic               add;
      logic [VALUE_W-1:0] val;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [ID_W-1:0]    rid;
      logic [ID_W-1:0]    fid;
      logic               changed;
      logic               rising;
      logic               hit;
      logic [ID_W-1:0]    hit_id;
      logic               overlap;
      logic               free_found;
   } token_type;

   typedef struct packed {
      logic               done;
      logic               write;
      logic [VALUE_W-1:0] lo;
      logic [VALUE_W-1:0] hi;
      logic [ID_W-1:0]    rid;
      logic [ID_W-1:0]    fid;
   } commit_type;

   typedef struct packed {
      logic                 pad;
      logic [STATUS_W-1:0]  add_status;
      logic [VALUE_W-1:0]   level;
      logic [CHANNEL_W-1:0] channel;
      logic                 from_default;
      logic [ID_W-1:0]      chosen_id;
      logic                 went_up;
      logic                 changed;
   } result_type;

endpackage

>>> rtl/svrt_cell.sv
`timescale 1ns / 1ps

module svrt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  svrt_pkg::token_type    token_i,
   input  svrt_pkg::commit_type   commit_i,
   output svrt_pkg::token_type    token_o
);
   import svrt_pkg::*;

   logic [VALUE_W-1:0] lo_ff;
   logic [VALUE_W-1:0] hi_ff;
   logic [ID_W-1:0]    rid_ff;
   logic [ID_W-1:0]    fid_ff;
   logic               used_ff;
   logic               claim_ff;
   logic               claim_in;
   token_type          token_ff;
   token_type          token_in;

   always_comb begin
      token_in = token_i;
      claim_in = claim_ff;
      if (token_i.valid && used_ff) begin
         if (token_i.add) begin
            if (token_i.lo <= hi_ff && lo_ff <= token_i.hi) begin
               token_in.overlap = 1'b1;
            end
         end else if (!token_i.hit && lo_ff <= token_i.val && token_i.val <= hi_ff) begin
            token_in.hit    = 1'b1;
            token_in.hit_id = token_i.rising ? rid_ff : fid_ff;
         end
      end
      if (token_i.valid && token_i.add && !used_ff && !token_i.free_found) begin
         token_in.free_found = 1'b1;
         claim_in            = 1'b1;
      end
      if (commit_i.done) begin
         claim_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
         used_ff        <= 1'b0;
         claim_ff       <= 1'b0;
      end else begin
         token_ff <= token_in;
         claim_ff <= claim_in;
         if (commit_i.done && commit_i.write && claim_ff) begin
            used_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (commit_i.done && commit_i.write && claim_ff) begin
         lo_ff  <= commit_i.lo;
         hi_ff  <= commit_i.hi;
         rid_ff <= commit_i.rid;
         fid_ff <= commit_i.fid;
      end
   end

   assign token_o = token_ff;

endmodule

>>> rtl/slot_value_range_trigger_top.sv
`timescale 1ns / 1ps
// channel  dir  ports                      payload
// req      in   req_tvalid/tready/tdata    tuser: action; tdata: sample, range_low,
//                + req_tuser               range_high, rise_id, fall_id
// rsp      out  rsp_tvalid/tready/tdata    changed, went_up, chosen_id, from_default,
//                                          channel, level, add_status
// csr      in   csr_wen/index/wdata        default_rise_id, default_fall_id, slot_number
//
// An item passes from acceptance to its result through the launch register, which loads
// at the accepting edge, then one register per table cell, the hold register and the
// output register. One item is in the row at a time; the next is taken once the
// previous result has reached the output register. The output register holds while
// rsp_tready is low.
// Synchronous reset empties the table and forgets the last sample.

module slot_value_range_trigger_top #(
   parameter int unsigned TABLE_DEPTH = svrt_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // sample[7:0], range_low[15:8], range_high[23:16], rise_id[31:24], fall_id[39:32]
   input  logic [svrt_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // changed[0], went_up[1], chosen_id[9:2], from_default[10], channel[20:11],
   // level[28:21], add_status[30:29], zero[31]
   output logic [svrt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [svrt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svrt_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import svrt_pkg::*;

   logic [ID_W-1:0]      default_rise_ff;
   logic [ID_W-1:0]      default_fall_ff;
   logic [CHANNEL_W-1:0] slot_number_ff;
   logic [VALUE_W-1:0]   last_sample_ff;
   logic                 last_known_ff;
   logic                 busy_ff;
   logic                 hold_valid_ff;
   result_type           hold_ff;
   result_type           result_in;
   logic                 rsp_valid_ff;
   result_type           rsp_data_ff;
   token_type            inject_ff;
   token_type            inject_in;
   token_type            tail;
   commit_type           commit;
   token_type            token_chain [TABLE_DEPTH+1];
   logic                 accept;
   logic                 move;

   assign accept     = req_tvalid && req_tready;
   assign move       = hold_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_rise_ff <= '0;
         default_fall_ff <= '0;
         slot_number_ff  <= SLOT_NUMBER_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_DEFAULT_RISE: default_rise_ff <= csr_wdata[ID_W-1:0];
            CSR_DEFAULT_FALL: default_fall_ff <= csr_wdata[ID_W-1:0];
            CSR_SLOT_NUMBER:  slot_number_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      inject_in            = '0;
      inject_in.valid      = accept;
      inject_in.add        = req_tuser;
      inject_in.val        = req_tdata[7:0];
      inject_in.lo         = req_tdata[15:8];
      inject_in.hi         = req_tdata[23:16];
      inject_in.rid        = req_tdata[31:24];
      inject_in.fid        = req_tdata[39:32];
      inject_in.changed    = !(last_known_ff && req_tdata[7:0] == last_sample_ff);
      inject_in.rising     = !last_known_ff || (req_tdata[7:0] > last_sample_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inject_ff.valid <= 1'b0;
      end else begin
         inject_ff <= inject_in;
      end
   end

   assign token_chain[0] = inject_ff;

   for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      svrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .token_i  (token_chain[g]),
         .commit_i (commit),
         .token_o  (token_chain[g+1])
      );
   end

   assign tail = token_chain[TABLE_DEPTH];

   always_comb begin
      result_in         = '0;
      result_in.channel = slot_number_ff;
      if (tail.add == ACTION_ADD) begin
         priority if (tail.lo > tail.hi) begin
            result_in.add_status = ADD_BAD_BOUNDS;
         end else if (tail.overlap) begin
            result_in.add_status = ADD_OVERLAP;
         end else if (!tail.free_found) begin
            result_in.add_status = ADD_TABLE_FULL;
         end else begin
            result_in.add_status = ADD_OK;
         end
      end else begin
         result_in.level = tail.val;
         if (tail.changed) begin
            result_in.changed = 1'b1;
            result_in.went_up = tail.rising;
            if (tail.hit && tail.hit_id != '0) begin
               result_in.chosen_id = tail.hit_id;
            end else begin
               result_in.chosen_id    = tail.rising ? default_rise_ff : default_fall_ff;
               result_in.from_default = 1'b1;
            end
         end
      end
   end

   always_comb begin
      commit.done  = tail.valid;
      commit.write = tail.valid && tail.add == ACTION_ADD && result_in.add_status == ADD_OK;
      commit.lo    = tail.lo;
      commit.hi    = tail.hi;
      commit.rid   = tail.rid;
      commit.fid   = tail.fid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sample_ff <= '0;
         last_known_ff  <= 1'b0;
         busy_ff        <= 1'b0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (tail.valid && tail.add == ACTION_SAMPLE && tail.changed) begin
            last_sample_ff <= tail.val;
            last_known_ff  <= 1'b1;
         end
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (move) begin
            busy_ff <= 1'b0;
         end
         if (tail.valid) begin
            hold_valid_ff <= 1'b1;
         end else if (move) begin
            hold_valid_ff <= 1'b0;
         end
         if (move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         hold_ff <= result_in;
      end
      if (move) begin
         rsp_data_ff <= hold_ff;
      end
   end

endmodule

>>> rtl/svrt_checker.sv
`timescale 1ns / 1ps

module svrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [svrt_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import svrt_pkg::*;

   result_type rsp;

   assign rsp = rsp_tdata;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while one is in the row");

   a_add_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.add_status != ADD_OK |->
         !rsp.changed && rsp.chosen_id == '0 && rsp.level == '0 && !rsp.from_default)
      else $error("rejected add carries sample fields");

   a_direction_needs_change: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.changed |-> !rsp.went_up && !rsp.from_default && rsp.chosen_id == '0)
      else $error("unchanged result carries an action");

endmodule

bind slot_value_range_trigger_top svrt_checker u_svrt_checker (.*);
